// ===== rtl/dccpf_pkg.sv =====
package dccpf_pkg;

  localparam int IMAGE_BYTES = 10;
  localparam int PKT_BYTES   = 5;
  localparam int BUILD_BYTES = PKT_BYTES + 1;

  localparam logic [21:0] PREAMBLE = 22'h3F_FFFF;

  localparam logic [2:0] COUNT_MIN = 3'd2;
  localparam logic [2:0] COUNT_MAX = 3'd5;

  localparam logic [6:0] FRAME_BITS_2 = 7'd49;
  localparam logic [6:0] FRAME_BITS_3 = 7'd58;
  localparam logic [6:0] FRAME_BITS_4 = 7'd67;
  localparam logic [6:0] FRAME_BITS_5 = 7'd76;

  localparam logic [3:0] LAST_IDX_2 = 4'd6;
  localparam logic [3:0] LAST_IDX_3 = 4'd7;
  localparam logic [3:0] LAST_IDX_4 = 4'd8;
  localparam logic [3:0] LAST_IDX_5 = 4'd9;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [PKT_BYTES-1:0][7:0] pkt;
    logic [2:0]                count;
    logic [7:0]                rpt;
    logic [3:0]                slot;
  } load_t;

endpackage

// ===== rtl/dcc_packet_framer.sv =====
// DCC packet framer.
// Input channel (in_valid/in_stall): one packet of 2 to 5 bytes, a logical
// register number and a repeat count per item. Output channel
// (out_valid/out_stall): the packed bit image, one frame byte per item,
// 7 to 10 items per packet, with last set on the final byte. Each output
// item also carries the physical slot, the image bit count and the repeat
// count.
// An accepted input item is registered together with the slot map read;
// the image is loaded into the serializer when it is free, and the first
// frame byte is then presented. The serializer sends bit_count / 8 rounded
// up frame bytes per packet, one frame byte per cycle while out_stall is
// low. A new packet is taken while the previous image is still being sent,
// and is loaded as the last byte of that image leaves.
// Reset clears the slot map so only logical register 0 is assigned
// (to slot 0) and discards any packet in flight.
// While out_stall is high the current frame byte holds; one further packet
// is buffered, then in_stall rises.
module dcc_packet_framer #(
  parameter int NUM_REGS = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] register_number,
  input  logic [7:0] packet_byte_0,
  input  logic [7:0] packet_byte_1,
  input  logic [7:0] packet_byte_2,
  input  logic [7:0] packet_byte_3,
  input  logic [7:0] packet_byte_4,
  input  logic [2:0] byte_count,
  input  logic [7:0] repeat_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic [3:0] byte_index,
  output logic [3:0] slot,
  output logic [6:0] bit_count,
  output logic [7:0] repeat_out,
  output logic       last
);

  localparam int MapDepth = NUM_REGS + 1;
  localparam int AddrW    = $clog2(MapDepth);

  logic [AddrW-1:0]   reg_tbl [256];
  logic               accept;
  logic               move;
  logic               ser_ready;
  logic               a_valid;
  dccpf_pkg::load_t   a_ld;
  dccpf_pkg::load_t   ld;
  logic [AddrW-1:0]   map_slot;
  logic [AddrW+3:0]   slot_ext;

  for (genvar g = 0; g < 256; g++) begin : g_mod
    localparam int Rem = g % MapDepth;
    assign reg_tbl[g] = AddrW'(Rem);
  end

  assign accept   = in_valid && !in_stall;
  assign move     = a_valid && ser_ready;
  assign in_stall = a_valid && !ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ld.pkt   <= {packet_byte_4, packet_byte_3, packet_byte_2,
                     packet_byte_1, packet_byte_0};
      a_ld.count <= byte_count;
      a_ld.rpt   <= repeat_count;
      a_ld.slot  <= '0;
    end
  end

  dccpf_slot_map #(
    .MapDepth (MapDepth),
    .AddrW    (AddrW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (reg_tbl[register_number]),
    .commit  (move),
    .slot    (map_slot)
  );

  assign slot_ext = {4'b0, map_slot};

  always_comb begin
    ld      = a_ld;
    ld.slot = slot_ext[3:0];
  end

  dccpf_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (move),
    .ld         (ld),
    .ready      (ser_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .slot       (slot),
    .bit_count  (bit_count),
    .repeat_out (repeat_out),
    .last       (last)
  );

  a_last_matches_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |->
      (bit_count == dccpf_pkg::FRAME_BITS_2 && byte_index == dccpf_pkg::LAST_IDX_2) ||
      (bit_count == dccpf_pkg::FRAME_BITS_3 && byte_index == dccpf_pkg::LAST_IDX_3) ||
      (bit_count == dccpf_pkg::FRAME_BITS_4 && byte_index == dccpf_pkg::LAST_IDX_4) ||
      (bit_count == dccpf_pkg::FRAME_BITS_5 && byte_index == dccpf_pkg::LAST_IDX_5))
    else $error("last byte does not match bit count");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      out_valid && byte_index == $past(byte_index) + 4'd1)
    else $error("frame byte index did not advance");

  a_first_index: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid && byte_index == 4'd0)
    else $error("new image does not start at byte 0");

  a_stage_filled: assert property (@(posedge clk) disable iff (rst)
    accept |=> a_valid)
    else $error("accepted item lost");

endmodule

// ===== rtl/dccpf_slot_map.sv =====
module dccpf_slot_map #(
  parameter int MapDepth = 16,
  parameter int AddrW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  input  logic             commit,
  output logic [AddrW-1:0] slot
);

  logic [AddrW-1:0]    mem [MapDepth];
  logic [AddrW-1:0]    rd_q;
  logic [AddrW-1:0]    cur_addr;
  logic                fwd_hit;
  logic [AddrW-1:0]    fwd_data;
  logic [MapDepth-1:0] assigned;
  logic [AddrW-1:0]    highest;
  logic [AddrW-1:0]    stored;
  logic                wr_en;

  // entry 0 is preassigned to slot 0 and never written
  always_comb begin
    stored = fwd_hit ? fwd_data : rd_q;
    if (cur_addr == '0) begin
      stored = '0;
    end
    slot  = assigned[cur_addr] ? stored : highest + AddrW'(1);
    wr_en = commit && !assigned[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_addr] <= slot;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      cur_addr <= rd_addr;
      fwd_data <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assigned <= MapDepth'(1);
      highest  <= '0;
      fwd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        assigned[cur_addr] <= 1'b1;
        highest            <= slot;
      end
      if (rd_en) begin
        fwd_hit <= wr_en && (cur_addr == rd_addr);
      end
    end
  end

endmodule

// ===== rtl/dccpf_serializer.sv =====
module dccpf_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dccpf_pkg::load_t    ld,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          frame_byte,
  output logic [3:0]          byte_index,
  output logic [3:0]          slot,
  output logic [6:0]          bit_count,
  output logic [7:0]          repeat_out,
  output logic                last
);

  logic [2:0]                                  cnt;
  dccpf_pkg::byte_t                            sum;
  dccpf_pkg::byte_t [dccpf_pkg::BUILD_BYTES-1:0] b;
  logic [dccpf_pkg::IMAGE_BYTES-1:0][7:0]      img_next;
  logic [6:0]                                  bits_next;
  logic [3:0]                                  last_next;

  logic [dccpf_pkg::IMAGE_BYTES-1:0][7:0]      img;
  logic [3:0]                                  idx;
  logic [3:0]                                  last_idx;
  logic                                        busy;
  logic [3:0]                                  sel;

  always_comb begin
    cnt = ld.count;
    if (cnt < dccpf_pkg::COUNT_MIN) begin
      cnt = dccpf_pkg::COUNT_MIN;
    end else if (cnt > dccpf_pkg::COUNT_MAX) begin
      cnt = dccpf_pkg::COUNT_MAX;
    end
    sum = '0;
    for (int i = 0; i < dccpf_pkg::PKT_BYTES; i++) begin
      if (3'(i) < cnt) begin
        sum = sum ^ ld.pkt[i];
      end
    end
    for (int k = 0; k < dccpf_pkg::BUILD_BYTES; k++) begin
      if (3'(k) < cnt) begin
        b[k] = ld.pkt[k];
      end else if (3'(k) == cnt) begin
        b[k] = sum;
      end else begin
        b[k] = '0;
      end
    end
    img_next = {dccpf_pkg::PREAMBLE, 1'b0, b[0], 1'b0, b[1], 1'b0, b[2],
                1'b0, b[3], 1'b0, b[4], 1'b0, b[5], 4'b0};
    case (cnt)
      3'd2: begin
        bits_next = dccpf_pkg::FRAME_BITS_2;
        last_next = dccpf_pkg::LAST_IDX_2;
      end
      3'd3: begin
        bits_next = dccpf_pkg::FRAME_BITS_3;
        last_next = dccpf_pkg::LAST_IDX_3;
      end
      3'd4: begin
        bits_next = dccpf_pkg::FRAME_BITS_4;
        last_next = dccpf_pkg::LAST_IDX_4;
      end
      default: begin
        bits_next = dccpf_pkg::FRAME_BITS_5;
        last_next = dccpf_pkg::LAST_IDX_5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && !out_stall) begin
      if (idx == last_idx) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      img        <= img_next;
      last_idx   <= last_next;
      bit_count  <= bits_next;
      slot       <= ld.slot;
      repeat_out <= ld.rpt;
    end
  end

  assign ready      = !busy || (!out_stall && idx == last_idx);
  assign out_valid  = busy;
  assign sel        = 4'(dccpf_pkg::IMAGE_BYTES - 1) - idx;
  assign frame_byte = img[sel];
  assign byte_index = idx;
  assign last       = (idx == last_idx);

endmodule

// ===== tb/tb_dcc_packet_framer.sv =====
module tb_dcc_packet_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS    = 15;
  localparam int MAP_DEPTH   = NUM_REGS + 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [7:0]      lreg;
    logic [4:0][7:0] pb;
    logic [2:0]      cnt;
    logic [7:0]      rpt;
  } dcc_pkt_t;

  typedef struct packed {
    logic [7:0] fb;
    logic [3:0] idx;
    logic [3:0] slot;
    logic [6:0] bits;
    logic [7:0] rpt;
    logic       lst;
  } frame_beat_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] register_number = '0;
  logic [7:0] packet_byte_0 = '0;
  logic [7:0] packet_byte_1 = '0;
  logic [7:0] packet_byte_2 = '0;
  logic [7:0] packet_byte_3 = '0;
  logic [7:0] packet_byte_4 = '0;
  logic [2:0] byte_count = 3'd2;
  logic [7:0] repeat_count = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic [3:0] byte_index;
  logic [3:0] slot;
  logic [6:0] bit_count;
  logic [7:0] repeat_out;
  logic       last;

  dcc_packet_framer #(.NUM_REGS(NUM_REGS)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .register_number(register_number),
    .packet_byte_0(packet_byte_0),
    .packet_byte_1(packet_byte_1),
    .packet_byte_2(packet_byte_2),
    .packet_byte_3(packet_byte_3),
    .packet_byte_4(packet_byte_4),
    .byte_count(byte_count),
    .repeat_count(repeat_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .byte_index(byte_index),
    .slot(slot),
    .bit_count(bit_count),
    .repeat_out(repeat_out),
    .last(last)
  );

  frame_beat_t frame_q[$];
  logic [3:0]  slot_of[MAP_DEPTH];
  logic        slot_used[MAP_DEPTH];
  logic [3:0]  top_slot;
  int          errors = 0;
  int          cycles = 0;
  bit          sender_gaps = 0;
  int          burst_left = 0;
  int          stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void clear_slot_map();
    for (int i = 0; i < MAP_DEPTH; i++) begin
      slot_of[i]   = '0;
      slot_used[i] = 1'b0;
    end
    slot_used[0] = 1'b1;
    top_slot     = '0;
  endfunction

  // maps the register, frames the packet and queues every frame byte
  function automatic void frame_packet(input dcc_pkt_t p);
    logic [7:0]  body[6];
    logic [79:0] img;
    logic [7:0]  xsum;
    int          n, lr, pos, nbits, nframe;
    frame_beat_t fbeat;
    if (p.cnt < dccpf_pkg::COUNT_MIN) n = int'(dccpf_pkg::COUNT_MIN);
    else if (p.cnt > dccpf_pkg::COUNT_MAX) n = int'(dccpf_pkg::COUNT_MAX);
    else n = int'(p.cnt);
    lr = int'(p.lreg) % MAP_DEPTH;
    xsum = '0;
    for (int i = 0; i < n; i++) begin
      body[i] = p.pb[i];
      xsum ^= p.pb[i];
    end
    body[n] = xsum;
    if (!slot_used[lr]) begin
      slot_of[lr]   = top_slot + 4'd1;
      slot_used[lr] = 1'b1;
    end
    if (slot_of[lr] > top_slot) top_slot = slot_of[lr];
    img = '0;
    img[79 -: 22] = dccpf_pkg::PREAMBLE;
    pos = 22;
    for (int k = 0; k <= n; k++) begin
      pos++;
      img[79 - pos -: 8] = body[k];
      pos += 8;
    end
    nbits = pos;
    nframe = (nbits + 7) / 8;
    for (int k = 0; k < nframe; k++) begin
      fbeat.fb   = img[79 - 8 * k -: 8];
      fbeat.idx  = 4'(k);
      fbeat.slot = slot_of[lr];
      fbeat.bits = 7'(nbits);
      fbeat.rpt  = p.rpt;
      fbeat.lst  = (k == nframe - 1);
      frame_q.push_back(fbeat);
    end
  endfunction

  task automatic send_packet(input dcc_pkt_t p);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid        <= 1'b1;
    register_number <= p.lreg;
    packet_byte_0   <= p.pb[0];
    packet_byte_1   <= p.pb[1];
    packet_byte_2   <= p.pb[2];
    packet_byte_3   <= p.pb[3];
    packet_byte_4   <= p.pb[4];
    byte_count      <= p.cnt;
    repeat_count    <= p.rpt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_packet(p);
  endtask

  function automatic dcc_pkt_t rand_packet();
    dcc_pkt_t p;
    p.lreg = 8'($urandom_range(0, 255));
    for (int i = 0; i < 5; i++) p.pb[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) p.cnt = 3'($urandom_range(0, 7));
    else p.cnt = 3'($urandom_range(2, 5));
    p.rpt = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic dcc_pkt_t mk_packet(input logic [7:0] lreg, input logic [39:0] bytes,
                                         input logic [2:0] cnt, input logic [7:0] rpt);
    dcc_pkt_t p;
    p.lreg = lreg;
    p.pb   = bytes;
    p.cnt  = cnt;
    p.rpt  = rpt;
    return p;
  endfunction

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          $error("unexpected frame byte %0h at index %0d", frame_byte, byte_index);
          errors++;
        end else begin
          want = frame_q.pop_front();
          if (frame_byte !== want.fb) begin
            $error("frame_byte exp %0h got %0h", want.fb, frame_byte);
            errors++;
          end
          if (byte_index !== want.idx) begin
            $error("byte_index exp %0d got %0d", want.idx, byte_index);
            errors++;
          end
          if (slot !== want.slot) begin
            $error("slot exp %0d got %0d", want.slot, slot);
            errors++;
          end
          if (bit_count !== want.bits) begin
            $error("bit_count exp %0d got %0d", want.bits, bit_count);
            errors++;
          end
          if (repeat_out !== want.rpt) begin
            $error("repeat_out exp %0d got %0d", want.rpt, repeat_out);
            errors++;
          end
          if (last !== want.lst) begin
            $error("last exp %0b got %0b", want.lst, last);
            errors++;
          end
        end
      end
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // extremes, all byte counts incl. clamped ones, register aliasing and slot order
  task automatic test_directed_packets();
    sender_gaps = 0;
    stall_pct   = 0;
    send_packet(mk_packet(8'd0,   {5{8'hFF}}, 3'd2, 8'd0));
    send_packet(mk_packet(8'd255, {5{8'h00}}, 3'd5, 8'd255));
    send_packet(mk_packet(8'd16,  40'h01_02_03_04_05, 3'd3, 8'd1));
    send_packet(mk_packet(8'd1,   40'h00_00_00_FF_FF, 3'd4, 8'd128));
    send_packet(mk_packet(8'd15,  40'hA5_5A_A5_5A_A5, 3'd5, 8'd7));
    send_packet(mk_packet(8'd2,   40'h11_22_33_44_55, 3'd0, 8'd3));
    send_packet(mk_packet(8'd3,   40'h11_22_33_44_55, 3'd1, 8'd4));
    send_packet(mk_packet(8'd4,   40'h11_22_33_44_55, 3'd6, 8'd5));
    send_packet(mk_packet(8'd5,   40'h11_22_33_44_55, 3'd7, 8'd6));
    send_packet(mk_packet(8'd17,  40'h00_00_00_00_FF, 3'd2, 8'd2));
    send_packet(mk_packet(8'd240, 40'h80_40_20_10_08, 3'd5, 8'd254));
    send_packet(mk_packet(8'd127, 40'hFF_FF_FF_FF_FF, 3'd4, 8'd127));
    send_packet(mk_packet(8'd128, 40'h7F_FE_01_80_55, 3'd3, 8'd9));
    send_packet(mk_packet(8'd31,  40'h5A_A5_5A_A5_5A, 3'd5, 8'd255));
    stall_pct = 60;
    send_packet(mk_packet(8'd6,   40'hC3_3C_C3_3C_C3, 3'd5, 8'd10));
    send_packet(mk_packet(8'd7,   40'h00_00_00_03_03, 3'd2, 8'd11));
    stall_pct = 0;
  endtask

  task automatic test_back_to_back();
    sender_gaps = 0;
    stall_pct   = 0;
    repeat (60) send_packet(rand_packet());
  endtask

  task automatic test_random_packets();
    sender_gaps = 1;
    burst_left  = 0;
    stall_pct   = 30;
    repeat (300) send_packet(rand_packet());
  endtask

  task automatic test_heavy_backpressure();
    sender_gaps = 0;
    stall_pct   = 80;
    repeat (50) send_packet(rand_packet());
  endtask

  initial begin
    clear_slot_map();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_back_to_back();
    test_random_packets();
    test_heavy_backpressure();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dccpf_pkg.sv
rtl/dccpf_slot_map.sv
rtl/dccpf_serializer.sv
rtl/dcc_packet_framer.sv
tb/tb_dcc_packet_framer.sv
